@@ hw/rtl/ircs_pkg.sv @@
// ----------------------------------------------------------------------------
// ircs_pkg
// Shared types and constants of the IRC control code stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package ircs_pkg;

	localparam int CHAR_WIDTH_DEF = 16;
	localparam int CHAR_W         = 16;
	localparam int NUM_REGS       = 8;
	localparam int REG_IDX_W      = 3;

	localparam logic [REG_IDX_W-1:0] REG_BOLD         = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLOR        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESET        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REVERSE      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNDERLINE    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CTCP         = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CRYPT_ESCAPE = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ICON         = 3'd7;

	localparam logic [CHAR_W-1:0] REG_RESET_VALS [NUM_REGS] = '{
		16'd2, 16'd3, 16'd15, 16'd22, 16'd31, 16'd1, 16'd30, 16'd28
	};

	localparam logic [CHAR_W-1:0] ASC_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] ASC_COMMA = 16'h002C;
	localparam logic [CHAR_W-1:0] ASC_0     = 16'h0030;
	localparam logic [CHAR_W-1:0] ASC_9     = 16'h0039;

	typedef enum logic [6:0] {
		PH_PLAIN = 7'b0000001,
		PH_COLOR = 7'b0000010,
		PH_FG1   = 7'b0000100,
		PH_FG2   = 7'b0001000,
		PH_COMMA = 7'b0010000,
		PH_BG1   = 7'b0100000,
		PH_ICON  = 7'b1000000
	} phase_t;

endpackage

`default_nettype wire

@@ hw/rtl/irc_control_code_stripper_top.sv @@
// ----------------------------------------------------------------------------
// irc_control_code_stripper_top
// Removes IRC formatting codes from a stream of text code units.
// ----------------------------------------------------------------------------
// Takes one code unit per cycle unless the output stalls, and passes on the
// kept text. Single-code controls are dropped, a colour code is dropped with
// its digits and comma, an icon code drops text up to the next space. Each
// item passes through the input register and the decode logic; an item that
// releases a held comma together with a kept character produces two output
// items and holds the input register until the second is taken. An item
// marked last that keeps nothing still produces one output item with tuser[0]
// low, and always returns the parser to plain text. Configuration writes must
// only be made while the stream is idle; the block does not hold them off.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_control_code_stripper_top #(
	parameter int CHAR_WIDTH = ircs_pkg::CHAR_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            cfg_we,
	input  wire logic [ircs_pkg::REG_IDX_W-1:0]  cfg_addr,
	input  wire logic [ircs_pkg::CHAR_W-1:0]     cfg_wdata,

	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [ircs_pkg::CHAR_W-1:0]     s_axis_tdata,  // in_char
	input  wire logic                            s_axis_tlast,  // in_last

	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [ircs_pkg::CHAR_W-1:0]          m_axis_tdata,  // out_char
	output logic [1:0]                           m_axis_tuser,  // char_valid, run_last
	output logic                                 m_axis_tlast   // end_of_text
);

	localparam int CMP_W = (CHAR_WIDTH < ircs_pkg::CHAR_W) ? CHAR_WIDTH : ircs_pkg::CHAR_W;

	logic [CMP_W-1:0] code_q [ircs_pkg::NUM_REGS];

	logic                  s1_valid_q;
	logic [CMP_W-1:0]      char_s1;
	logic                  last_s1;
	logic                  sub_q;
	ircs_pkg::phase_t      phase_q;

	logic [ircs_pkg::CHAR_W-1:0] c16;
	logic [ircs_pkg::NUM_REGS-1:0] hit;
	logic                  is_single, is_color, is_icon, is_digit, is_comma;
	logic                  pc_emit;
	ircs_pkg::phase_t      pc_next;
	logic                  emit_comma, emit_char;
	ircs_pkg::phase_t      phase_nx;
	logic [1:0]            total;
	logic                  out_ready, retire, load_out;
	logic [ircs_pkg::CHAR_W-1:0] slot_char;
	logic                  slot_valid, slot_run_last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ircs_pkg::NUM_REGS; i++) begin
				code_q[i] <= ircs_pkg::REG_RESET_VALS[i][CMP_W-1:0];
			end
		end else if (cfg_we) begin
			code_q[cfg_addr] <= cfg_wdata[CMP_W-1:0];
		end
	end

	// decode
	assign c16 = ircs_pkg::CHAR_W'(char_s1);

	always_comb begin
		for (int i = 0; i < ircs_pkg::NUM_REGS; i++) begin
			hit[i] = (char_s1 == code_q[i]);
		end
		is_single = hit[ircs_pkg::REG_BOLD] | hit[ircs_pkg::REG_RESET] |
			hit[ircs_pkg::REG_REVERSE] | hit[ircs_pkg::REG_UNDERLINE] |
			hit[ircs_pkg::REG_CTCP] | hit[ircs_pkg::REG_CRYPT_ESCAPE];
		is_color = hit[ircs_pkg::REG_COLOR];
		is_icon  = hit[ircs_pkg::REG_ICON];
		is_digit = c16 inside {[ircs_pkg::ASC_0:ircs_pkg::ASC_9]};
		is_comma = (c16 == ircs_pkg::ASC_COMMA);

		pc_emit = !(is_single | is_color | is_icon);
		if (is_single) begin
			pc_next = ircs_pkg::PH_PLAIN;
		end else if (is_color) begin
			pc_next = ircs_pkg::PH_COLOR;
		end else if (is_icon) begin
			pc_next = ircs_pkg::PH_ICON;
		end else begin
			pc_next = ircs_pkg::PH_PLAIN;
		end

		emit_comma = 1'b0;
		emit_char  = pc_emit;
		phase_nx   = pc_next;
		case (phase_q)
			ircs_pkg::PH_COLOR: begin
				if (is_digit) begin
					emit_char = 1'b0;
					phase_nx  = ircs_pkg::PH_FG1;
				end
			end
			ircs_pkg::PH_FG1: begin
				if (is_digit) begin
					emit_char = 1'b0;
					phase_nx  = ircs_pkg::PH_FG2;
				end else if (is_comma) begin
					emit_char = 1'b0;
					phase_nx  = ircs_pkg::PH_COMMA;
				end
			end
			ircs_pkg::PH_FG2: begin
				if (is_comma) begin
					emit_char = 1'b0;
					phase_nx  = ircs_pkg::PH_COMMA;
				end
			end
			ircs_pkg::PH_COMMA: begin
				if (is_digit) begin
					emit_char = 1'b0;
					phase_nx  = ircs_pkg::PH_BG1;
				end else begin
					emit_comma = 1'b1;
				end
			end
			ircs_pkg::PH_BG1: begin
				if (is_digit) begin
					emit_char = 1'b0;
					phase_nx  = ircs_pkg::PH_PLAIN;
				end
			end
			ircs_pkg::PH_ICON: begin
				emit_char = (c16 == ircs_pkg::ASC_SPACE);
				phase_nx  = emit_char ? ircs_pkg::PH_PLAIN : ircs_pkg::PH_ICON;
			end
			default: ;
		endcase
		if (last_s1) begin
			phase_nx = ircs_pkg::PH_PLAIN;
		end

		if (emit_comma && emit_char) begin
			total = 2'd2;
		end else if (emit_comma || emit_char || last_s1) begin
			total = 2'd1;
		end else begin
			total = 2'd0;
		end

		// second item is always the kept character
		if (sub_q || (emit_char && !emit_comma)) begin
			slot_char = c16;
		end else if (emit_comma) begin
			slot_char = ircs_pkg::ASC_COMMA;
		end else begin
			slot_char = '0;
		end
		slot_valid    = sub_q | emit_comma | emit_char;
		slot_run_last = sub_q | (total == 2'd1);
	end

	// handshake
	assign out_ready     = !m_axis_tvalid || m_axis_tready;
	assign retire        = s1_valid_q &&
		((total == 2'd0) || (out_ready && ((total == 2'd1) || sub_q)));
	assign load_out      = s1_valid_q && (total != 2'd0) && out_ready;
	assign s_axis_tready = !s1_valid_q || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			sub_q      <= 1'b0;
			phase_q    <= ircs_pkg::PH_PLAIN;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (retire) begin
				sub_q   <= 1'b0;
				phase_q <= phase_nx;
			end else if (load_out && (total == 2'd2)) begin
				sub_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata[CMP_W-1:0];
			last_s1 <= s_axis_tlast;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_axis_tvalid <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_axis_tdata <= slot_char;
			m_axis_tuser <= {slot_run_last, slot_valid};
			m_axis_tlast <= last_s1 && slot_run_last;
		end
	end

`ifndef SYNTH
	a_sub_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (s1_valid_q && emit_comma && emit_char))
		else $error("second result pending without a two-result item");

	a_last_to_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && last_s1) |=> (phase_q == ircs_pkg::PH_PLAIN))
		else $error("parser not back in plain text after last item");

	a_eot_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
		else $error("end of text on an item that is not last of its run");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !sub_q && (total == 2'd2)) |=> (sub_q && s1_valid_q))
		else $error("comma released without its following character");
`endif

endmodule

`default_nettype wire

@@ tb/irc_control_code_stripper_top_tb.sv @@
// ----------------------------------------------------------------------------
// irc_control_code_stripper_top_tb
// Self-checking testbench for the IRC control code stripper.
// ----------------------------------------------------------------------------
// Feeds code units over the input stream and predicts the stripped text with a
// behavioural parser of its own. Every output item is checked field by field
// against the oldest prediction. A short table of directed rows comes first.
// Random phases follow, each under different code register settings:
// defaults, all zero, all ones, codes overlapping punctuation and digits, and
// random values. Random text is mostly well-formed colour and icon sequences
// mixed with stray codes, digits and raw values. Both stream sides idle at
// random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irc_control_code_stripper_top_tb;

	typedef struct packed {
		logic [ircs_pkg::CHAR_W-1:0] ch;
		logic                        kept;
		logic                        eot;
		logic                        rl;
	} strip_res_t;

	typedef struct {
		logic [ircs_pkg::CHAR_W-1:0] ch;
		bit                          lst;
		bit                          typed;
		bit                          none;
		strip_res_t                  res;
	} text_row_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 220;
	localparam int SETTLE_CYCLES  = 16;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [ircs_pkg::REG_IDX_W-1:0]    cfg_addr;
	logic [ircs_pkg::CHAR_W-1:0]       cfg_wdata;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [ircs_pkg::CHAR_W-1:0]       s_axis_tdata;
	logic                              s_axis_tlast;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [ircs_pkg::CHAR_W-1:0]       m_axis_tdata;
	logic [1:0]                        m_axis_tuser;
	logic                              m_axis_tlast;

	irc_control_code_stripper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	logic [ircs_pkg::CHAR_W-1:0] code_reg  [ircs_pkg::NUM_REGS];
	logic [ircs_pkg::CHAR_W-1:0] next_code [ircs_pkg::NUM_REGS];
	ircs_pkg::phase_t            strip_phase;
	strip_res_t                  step_out [$];
	strip_res_t                  kept_text [$];
	int                          errors;
	int                          quiet_cycles;
	bit                          steady;
	bit                          hold_off;

	localparam strip_res_t NO_RES = '0;

	text_row_t text_rows [30] = '{
		'{16'h0041, 1'b0, 1'b1, 1'b0, '{16'h0041, 1'b1, 1'b0, 1'b1}},
		'{16'h0000, 1'b0, 1'b1, 1'b0, '{16'h0000, 1'b1, 1'b0, 1'b1}},
		'{16'hFFFF, 1'b0, 1'b1, 1'b0, '{16'hFFFF, 1'b1, 1'b0, 1'b1}},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_BOLD],         1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_UNDERLINE],    1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_RESET],        1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_REVERSE],      1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_CTCP],         1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_CRYPT_ESCAPE], 1'b0, 1'b1, 1'b1, NO_RES},
		// full colour sequence, then a plain character
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_COLOR],        1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0031, 1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::ASC_COMMA, 1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0033, 1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0078, 1'b0, 1'b0, 1'b0, NO_RES},
		// comma with no background digit is released
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_COLOR],        1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0035, 1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::ASC_COMMA, 1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h007A, 1'b0, 1'b0, 1'b0, NO_RES},
		// third digit passes
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_COLOR],        1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0031, 1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0032, 1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0037, 1'b0, 1'b0, 1'b0, NO_RES},
		// icon name up to the space
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_ICON],         1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0061, 1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::ASC_SPACE, 1'b0, 1'b0, 1'b0, NO_RES},
		// trailing comma at end of text is dropped
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_COLOR],        1'b0, 1'b1, 1'b1, NO_RES},
		'{16'h0039, 1'b0, 1'b1, 1'b1, NO_RES},
		'{ircs_pkg::ASC_COMMA, 1'b1, 1'b1, 1'b0,
			'{16'h0000, 1'b0, 1'b1, 1'b1}},
		'{ircs_pkg::REG_RESET_VALS[ircs_pkg::REG_BOLD], 1'b1, 1'b1, 1'b0,
			'{16'h0000, 1'b0, 1'b1, 1'b1}},
		'{16'h0042, 1'b1, 1'b1, 1'b0, '{16'h0042, 1'b1, 1'b1, 1'b1}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---- stripping predictor ----

	function automatic bit is_digit(input logic [ircs_pkg::CHAR_W-1:0] c);
		return c >= ircs_pkg::ASC_0 && c <= ircs_pkg::ASC_9;
	endfunction

	function automatic void keep_char(input logic [ircs_pkg::CHAR_W-1:0] c);
		step_out.push_back('{c, 1'b1, 1'b0, 1'b0});
	endfunction

	function automatic void plain_text(input logic [ircs_pkg::CHAR_W-1:0] c);
		if (c == code_reg[ircs_pkg::REG_BOLD] || c == code_reg[ircs_pkg::REG_RESET] ||
		    c == code_reg[ircs_pkg::REG_REVERSE] ||
		    c == code_reg[ircs_pkg::REG_UNDERLINE] ||
		    c == code_reg[ircs_pkg::REG_CTCP] ||
		    c == code_reg[ircs_pkg::REG_CRYPT_ESCAPE]) begin
			strip_phase = ircs_pkg::PH_PLAIN;
		end else if (c == code_reg[ircs_pkg::REG_COLOR]) begin
			strip_phase = ircs_pkg::PH_COLOR;
		end else if (c == code_reg[ircs_pkg::REG_ICON]) begin
			strip_phase = ircs_pkg::PH_ICON;
		end else begin
			strip_phase = ircs_pkg::PH_PLAIN;
			keep_char(c);
		end
	endfunction

	function automatic void predict_strip(input logic [ircs_pkg::CHAR_W-1:0] c,
	                                      input bit lst);
		step_out.delete();
		case (strip_phase)
			ircs_pkg::PH_COLOR: begin
				if (is_digit(c)) strip_phase = ircs_pkg::PH_FG1;
				else plain_text(c);
			end
			ircs_pkg::PH_FG1: begin
				if (is_digit(c)) strip_phase = ircs_pkg::PH_FG2;
				else if (c == ircs_pkg::ASC_COMMA) strip_phase = ircs_pkg::PH_COMMA;
				else plain_text(c);
			end
			ircs_pkg::PH_FG2: begin
				if (c == ircs_pkg::ASC_COMMA) strip_phase = ircs_pkg::PH_COMMA;
				else plain_text(c);
			end
			ircs_pkg::PH_COMMA: begin
				if (is_digit(c)) begin
					strip_phase = ircs_pkg::PH_BG1;
				end else begin
					keep_char(ircs_pkg::ASC_COMMA);
					plain_text(c);
				end
			end
			ircs_pkg::PH_BG1: begin
				if (is_digit(c)) strip_phase = ircs_pkg::PH_PLAIN;
				else plain_text(c);
			end
			ircs_pkg::PH_ICON: begin
				if (c == ircs_pkg::ASC_SPACE) begin
					strip_phase = ircs_pkg::PH_PLAIN;
					keep_char(c);
				end
			end
			default: plain_text(c);
		endcase
		if (lst) begin
			if (step_out.size() == 0)
				step_out.push_back(NO_RES);
			step_out[step_out.size()-1].eot = 1'b1;
			strip_phase = ircs_pkg::PH_PLAIN;
		end
		if (step_out.size() > 0)
			step_out[step_out.size()-1].rl = 1'b1;
	endfunction

	// ---- stimulus helpers ----

	task automatic send_char(input logic [ircs_pkg::CHAR_W-1:0] c, input bit lst,
	                         input bit typed, input bit none, input strip_res_t res);
		while (!steady && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_strip(c, lst);
		if (typed) begin
			if (!none)
				kept_text.push_back(res);
		end else begin
			foreach (step_out[i])
				kept_text.push_back(step_out[i]);
		end
	endtask

	task automatic feed(input logic [ircs_pkg::CHAR_W-1:0] c);
		send_char(c, $urandom_range(15) == 0, 1'b0, 1'b0, NO_RES);
	endtask

	function automatic logic [ircs_pkg::CHAR_W-1:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 30) return code_reg[$urandom_range(ircs_pkg::NUM_REGS-1)];
		if (r < 50) return ircs_pkg::ASC_0 + ircs_pkg::CHAR_W'($urandom_range(9));
		if (r < 58) return ircs_pkg::ASC_COMMA;
		if (r < 66) return ircs_pkg::ASC_SPACE;
		if (r < 80) return ircs_pkg::CHAR_W'($urandom_range(16'h0061, 16'h007A));
		return ircs_pkg::CHAR_W'($urandom);
	endfunction

	function automatic logic [ircs_pkg::CHAR_W-1:0] pick_digit();
		return ircs_pkg::ASC_0 + ircs_pkg::CHAR_W'($urandom_range(9));
	endfunction

	task automatic drain_and_settle();
		while (kept_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_codes();
		for (int i = 0; i < ircs_pkg::NUM_REGS; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= ircs_pkg::REG_IDX_W'(i);
			cfg_wdata <= next_code[i];
			code_reg[i] = next_code[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_text(input int count);
		int n;
		int sel;
		int k;
		n = 0;
		while (n < count) begin
			sel = $urandom_range(9);
			if (sel < 4) begin
				feed(code_reg[ircs_pkg::REG_COLOR]);
				feed(pick_digit());
				n += 2;
				if ($urandom_range(1)) begin
					feed(pick_digit());
					n++;
				end
				case ($urandom_range(3))
					0: begin
						feed(ircs_pkg::ASC_COMMA);
						feed(pick_digit());
						n += 2;
						if ($urandom_range(1)) begin
							feed(pick_digit());
							n++;
						end
					end
					1: begin
						feed(ircs_pkg::ASC_COMMA);
						n++;
					end
					default: ;
				endcase
				feed(pick_char());
				n++;
			end else if (sel == 4) begin
				k = $urandom_range(3);
				feed(code_reg[ircs_pkg::REG_ICON]);
				repeat (k) feed(pick_char());
				feed(ircs_pkg::ASC_SPACE);
				n += 2 + k;
			end else begin
				feed(pick_char());
				n++;
			end
		end
	endtask

	// ---- sink ----

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				m_axis_tready <= steady || $urandom_range(99) >= 28;
			end
		end
	end

	always @(posedge clk) begin
		strip_res_t got;
		strip_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
			if (kept_text.size() == 0) begin
				$display("%0t: unexpected item: exp none, got ch=%h kept=%b eot=%b rl=%b",
				         $time, got.ch, got.kept, got.eot, got.rl);
				errors++;
			end else begin
				want = kept_text.pop_front();
				if (got.ch !== want.ch || got.kept !== want.kept ||
				    got.eot !== want.eot || got.rl !== want.rl) begin
					$display({"%0t: mismatch: exp ch=%h kept=%b eot=%b rl=%b, ",
					          "got ch=%h kept=%b eot=%b rl=%b"},
					         $time, want.ch, want.kept, want.eot, want.rl,
					         got.ch, got.kept, got.eot, got.rl);
					errors++;
				end
			end
		end
	end

	// ---- watchdog ----

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---- main sequence ----

	initial begin
		errors        = 0;
		quiet_cycles  = 0;
		steady        = 1'b0;
		hold_off      = 1'b0;
		strip_phase   = ircs_pkg::PH_PLAIN;
		for (int i = 0; i < ircs_pkg::NUM_REGS; i++)
			code_reg[i] = ircs_pkg::REG_RESET_VALS[i];
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_addr      <= '0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (text_rows[i])
			send_char(text_rows[i].ch, text_rows[i].lst, text_rows[i].typed,
			          text_rows[i].none, text_rows[i].res);

		// defaults, with a long sink hold-off to back up the input
		hold_off = 1'b1;
		random_text(PHASE_ITEMS);
		s_axis_tvalid <= 1'b0;
		drain_and_settle();

		for (int p = 0; p < 5; p++) begin
			for (int i = 0; i < ircs_pkg::NUM_REGS; i++) begin
				case (p)
					0: next_code[i] = 16'h0000;
					1: next_code[i] = 16'hFFFF;
					3: next_code[i] = ircs_pkg::CHAR_W'($urandom_range(63));
					4: next_code[i] = ircs_pkg::CHAR_W'($urandom);
					default: next_code[i] = ircs_pkg::REG_RESET_VALS[i];
				endcase
			end
			if (p == 2) begin
				// codes overlapping digits, comma and space
				next_code[ircs_pkg::REG_BOLD]         = 16'h0035;
				next_code[ircs_pkg::REG_COLOR]        = ircs_pkg::ASC_COMMA;
				next_code[ircs_pkg::REG_RESET]        = 16'h0041;
				next_code[ircs_pkg::REG_REVERSE]      = 16'hFFFF;
				next_code[ircs_pkg::REG_UNDERLINE]    = 16'h0000;
				next_code[ircs_pkg::REG_CTCP]         = 16'h0061;
				next_code[ircs_pkg::REG_CRYPT_ESCAPE] = ircs_pkg::ASC_0;
				next_code[ircs_pkg::REG_ICON]         = ircs_pkg::ASC_SPACE;
			end
			apply_codes();
			steady = (p == 4);
			random_text(PHASE_ITEMS);
			s_axis_tvalid <= 1'b0;
			drain_and_settle();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
